// ----- hdl/cleb_pkg.sv -----
package cleb_pkg;

    localparam int BUFFER_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int IDX_W        = 10;
    localparam int OUT_CNT_W    = 11;
    // wide enough for both a count and a read index
    localparam int CMP_W        = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [7:0] KEY_LEFT      = 8'h3C;
    localparam logic [7:0] KEY_RIGHT     = 8'h3E;
    localparam logic [7:0] KEY_BACKSPACE = 8'h2D;

    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       key_code;
        logic [IDX_W-1:0] read_index;
    } in_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] text_length;
        logic [OUT_CNT_W-1:0] cursor_pos;
        logic [7:0]           read_char;
        logic                 read_valid;
        logic                 dropped;
    } out_t;

    typedef struct packed {
        logic [CNT_W-1:0]  before_next;
        logic [CNT_W-1:0]  after_next;
        logic              wr_before_en;
        logic [ADDR_W-1:0] wr_before_addr;
        logic              wr_after_en;
        logic [ADDR_W-1:0] wr_after_addr;
        logic [7:0]        wr_data;
        out_t              result;
    } step_t;

    // Count to output field width: zero-extend or keep the low bits.
    function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] c);
        logic [OUT_CNT_W+CNT_W-1:0] tmp;
        tmp = {{OUT_CNT_W{1'b0}}, c};
        return tmp[OUT_CNT_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] cnt_ext(input logic [CNT_W-1:0] c);
        logic [CMP_W+CNT_W-1:0] tmp;
        tmp = {{CMP_W{1'b0}}, c};
        return tmp[CMP_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] idx_ext(input logic [IDX_W-1:0] i);
        logic [CMP_W+IDX_W-1:0] tmp;
        tmp = {{CMP_W{1'b0}}, i};
        return tmp[CMP_W-1:0];
    endfunction

endpackage

// ----- hdl/cleb_ram.sv -----
module cleb_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/cleb_step.sv -----
module cleb_step (
    input  cleb_pkg::in_t                  req,
    input  logic [cleb_pkg::CNT_W-1:0]     before_count,
    input  logic [cleb_pkg::CNT_W-1:0]     after_count,
    input  logic                           read_from_after,
    input  logic [7:0]                     rd_before,
    input  logic [7:0]                     rd_after,
    output cleb_pkg::step_t                step
);

    logic [cleb_pkg::CNT_W-1:0] total;
    logic [cleb_pkg::CNT_W-1:0] total_next;

    assign total = before_count + after_count;

    always_comb begin
        step                = '0;
        step.before_next    = before_count;
        step.after_next     = after_count;
        step.wr_before_addr = before_count[cleb_pkg::ADDR_W-1:0];
        step.wr_after_addr  = after_count[cleb_pkg::ADDR_W-1:0];
        unique case (req.operation)
            cleb_pkg::OP_KEY: begin
                priority if (req.key_code == cleb_pkg::KEY_LEFT) begin
                    if (before_count != '0) begin
                        step.before_next = before_count - 1'b1;
                        step.after_next  = after_count + 1'b1;
                        step.wr_after_en = 1'b1;
                        step.wr_data     = rd_before;
                    end
                end else if (req.key_code == cleb_pkg::KEY_RIGHT) begin
                    if (after_count != '0) begin
                        step.after_next   = after_count - 1'b1;
                        step.before_next  = before_count + 1'b1;
                        step.wr_before_en = 1'b1;
                        step.wr_data      = rd_after;
                    end
                end else if (req.key_code == cleb_pkg::KEY_BACKSPACE) begin
                    if (before_count != '0) begin
                        step.before_next = before_count - 1'b1;
                    end
                end else begin
                    if (total < cleb_pkg::CNT_W'(cleb_pkg::BUFFER_DEPTH)) begin
                        step.before_next  = before_count + 1'b1;
                        step.wr_before_en = 1'b1;
                        step.wr_data      = req.key_code;
                    end else begin
                        step.result.dropped = 1'b1;
                    end
                end
            end
            cleb_pkg::OP_READ: begin
                if (cleb_pkg::idx_ext(req.read_index) < cleb_pkg::cnt_ext(total)) begin
                    step.result.read_valid = 1'b1;
                    step.result.read_char  = read_from_after ? rd_after : rd_before;
                end
            end
            cleb_pkg::OP_CLEAR: begin
                step.before_next = '0;
                step.after_next  = '0;
            end
            default: begin
            end
        endcase
        total_next              = step.before_next + step.after_next;
        step.result.text_length = cleb_pkg::to_out_cnt(total_next);
        step.result.cursor_pos  = cleb_pkg::to_out_cnt(step.before_next);
    end

endmodule

// ----- hdl/cursor_line_edit_buffer_unit.sv -----
// Line editor holding one line of text as a gap buffer: two 8-bit stacks in
// synchronous RAM, one for the characters before the cursor and one for those
// after it. On acceptance of a request the needed stack entry is addressed in
// the RAM; in the finish state its registered read data is written to the
// other stack (cursor moves), or returned (reads), while the counts advance
// and the result is loaded into the output register. A new request is
// accepted while a result still waits; the block stalls in its finish state
// only if the previous result has not yet been taken. No clearing pass is
// needed: entries beyond the counts are never read.
module cursor_line_edit_buffer_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cleb_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output cleb_pkg::out_t m_payload
);

    cleb_pkg::state_t              state_reg, state_next;
    logic [cleb_pkg::CNT_W-1:0]    before_count_reg, before_count_next;
    logic [cleb_pkg::CNT_W-1:0]    after_count_reg, after_count_next;
    cleb_pkg::in_t                 req_reg;
    logic                          from_after_reg;
    logic                          m_valid_reg, m_valid_next;
    cleb_pkg::out_t                m_payload_reg;

    logic                          accept;
    logic                          commit;
    logic [cleb_pkg::CMP_W-1:0]    idx_w;
    logic [cleb_pkg::CMP_W-1:0]    before_w;
    logic [cleb_pkg::CMP_W-1:0]    after_w;
    logic                          idx_in_before;
    logic [cleb_pkg::CMP_W-1:0]    rd_before_addr_w;
    logic [cleb_pkg::CMP_W-1:0]    rd_after_addr_w;
    logic [7:0]                    rd_before;
    logic [7:0]                    rd_after;
    cleb_pkg::step_t               step;

    assign accept = s_valid && s_ready;

    // Address generation at acceptance: a read picks the stack holding the
    // index; a cursor move reads the top of the stack it pops.
    assign idx_w         = cleb_pkg::idx_ext(s_payload.read_index);
    assign before_w      = cleb_pkg::cnt_ext(before_count_reg);
    assign after_w       = cleb_pkg::cnt_ext(after_count_reg);
    assign idx_in_before = idx_w < before_w;

    always_comb begin
        rd_before_addr_w = before_w - 1'b1;
        rd_after_addr_w  = after_w - 1'b1;
        if (s_payload.operation == cleb_pkg::OP_READ) begin
            rd_before_addr_w = idx_w;
            // after stack is stored reversed: top is the character at the cursor
            rd_after_addr_w  = before_w + after_w - 1'b1 - idx_w;
        end
    end

    cleb_ram #(
        .DEPTH (cleb_pkg::BUFFER_DEPTH),
        .WIDTH (8)
    ) u_before_ram (
        .aclk    (aclk),
        .wr_en   (commit && step.wr_before_en),
        .wr_addr (step.wr_before_addr),
        .wr_data (step.wr_data),
        .rd_en   (accept),
        .rd_addr (rd_before_addr_w[cleb_pkg::ADDR_W-1:0]),
        .rd_data (rd_before)
    );

    cleb_ram #(
        .DEPTH (cleb_pkg::BUFFER_DEPTH),
        .WIDTH (8)
    ) u_after_ram (
        .aclk    (aclk),
        .wr_en   (commit && step.wr_after_en),
        .wr_addr (step.wr_after_addr),
        .wr_data (step.wr_data),
        .rd_en   (accept),
        .rd_addr (rd_after_addr_w[cleb_pkg::ADDR_W-1:0]),
        .rd_data (rd_after)
    );

    cleb_step u_step (
        .req             (req_reg),
        .before_count    (before_count_reg),
        .after_count     (after_count_reg),
        .read_from_after (from_after_reg),
        .rd_before       (rd_before),
        .rd_after        (rd_after),
        .step            (step)
    );

    // Sequencer: accept in idle, finish once the output register is free.
    always_comb begin
        state_next        = state_reg;
        s_ready           = 1'b0;
        commit            = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;
        before_count_next = before_count_reg;
        after_count_next  = after_count_reg;
        unique case (state_reg)
            cleb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = cleb_pkg::ST_FINISH;
                end
            end
            cleb_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    commit            = 1'b1;
                    m_valid_next      = 1'b1;
                    before_count_next = step.before_next;
                    after_count_next  = step.after_next;
                    state_next        = cleb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cleb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= cleb_pkg::ST_IDLE;
            before_count_reg <= '0;
            after_count_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            before_count_reg <= before_count_next;
            after_count_reg  <= after_count_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Hold the request and result payloads; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg        <= s_payload;
            from_after_reg <= !idx_in_before;
        end
        if (commit) begin
            m_payload_reg <= step.result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
